FILE: rtl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shorthand for the clocked checks used inside the list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define PLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Widths, item types, command and status codes shared by the engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 3;
  localparam int ECNT_W   = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = POS_W + 1;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ST_W-1:0]   st_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [ECNT_W-1:0] ecnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam kind_t K_INS_FRONT = 3'd0;
  localparam kind_t K_INS_AT    = 3'd1;
  localparam kind_t K_INS_END   = 3'd2;
  localparam kind_t K_DEL_FRONT = 3'd3;
  localparam kind_t K_DEL_AT    = 3'd4;
  localparam kind_t K_DEL_END   = 3'd5;
  localparam kind_t K_REVERSE   = 3'd6;
  localparam kind_t K_READ_ALL  = 3'd7;

  localparam st_t ST_OK        = 3'd0;
  localparam st_t ST_EMPTY     = 3'd1;
  localparam st_t ST_TOO_LARGE = 3'd2;
  localparam st_t ST_BELOW_ONE = 3'd3;
  localparam st_t ST_FULL      = 3'd4;

  typedef struct packed {
    kind_t                    kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    st_t                      status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    ecnt_t                    element_count;
  } out_item_t;

endpackage : ple_pkg

`default_nettype wire

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words held in a RAM, edited one command at a time.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ channel (valid/ready) as one item each:
// insert at the front, at a 1-based position or at the end, delete likewise,
// reverse, or read the whole list. Results leave on the out_ channel from a
// single output register. A read of a non-empty list gives one item per
// element with last set on the final one; every other command gives one
// status item. Moved words pass once each through the single write port of
// the element RAM. An insert not at the end first moves the elements from
// the tail down to its slot up by one, then writes the new one; a delete not
// at the end moves the elements behind its slot down by one; a reverse reads
// both ends of a pair together and writes them back swapped, working inward;
// a read fetches the elements one at a time.
// The engine takes no new command until the previous one has been worked off
// and its final result loaded; a result waiting in the output register does
// not block the next command. When the receiver stalls, the register holds
// its item and the engine waits before loading the next one.
// Reset empties the list at once; the RAM is not cleared, since only entries
// below the element count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ple_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ple_pkg::out_item_t     out_data
);

`include "positional_list_engine_macros.svh"

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SHIFT_UP = 4'd1;
  localparam logic [3:0] S_SHIFT_DN = 4'd2;
  localparam logic [3:0] S_FLUSH    = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_REV_RD   = 4'd5;
  localparam logic [3:0] S_REV_WA   = 4'd6;
  localparam logic [3:0] S_REV_WB   = 4'd7;
  localparam logic [3:0] S_RD_ADDR  = 4'd8;
  localparam logic [3:0] S_RD_DATA  = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  // Control state.
  logic [3:0]          state_r, state_nxt;
  ple_pkg::cnt_t       count_r, count_nxt;
  ple_pkg::cnt_t       idx_r, idx_nxt;
  ple_pkg::cnt_t       hi_r, hi_nxt;
  logic                mv_pend_r, mv_pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload state.
  ple_pkg::idx_t       mv_dst_r, mv_dst_nxt;
  ple_pkg::idx_t       slot_r, slot_nxt;
  ple_pkg::kind_t      kind_r, kind_nxt;
  ple_pkg::word_t      value_r, value_nxt;
  ple_pkg::word_t      tmp_r, tmp_nxt;
  ple_pkg::st_t        st_r, st_nxt;
  ple_pkg::out_item_t  out_r, out_nxt;

  // RAM port signals.
  logic                ram_we;
  ple_pkg::idx_t       ram_waddr;
  ple_pkg::word_t      ram_wdata;
  ple_pkg::idx_t       ram_raddr_a;
  ple_pkg::idx_t       ram_raddr_b;
  ple_pkg::word_t      ram_rdata_a;
  ple_pkg::word_t      ram_rdata_b;

  // Command decode.
  logic                in_fire;
  logic                slot_free;
  logic                is_empty;
  logic                is_full;
  ple_pkg::cmp_t       pos_w;
  ple_pkg::cmp_t       cnt_w;
  logic                dec_ins;
  logic                dec_rem;
  logic                dec_rev;
  logic                dec_read;
  ple_pkg::st_t        dec_st;
  ple_pkg::cmp_t       dec_slot;
  logic                rd_last;

  // Checking helpers.
  logic                count_ok;
  logic                in_move;
  logic                out_st_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == ple_pkg::cnt_t'(ple_pkg::CAPACITY));
  assign pos_w    = ple_pkg::cmp_t'(in_data.position);
  assign cnt_w    = ple_pkg::cmp_t'(count_r);
  assign rd_last  = ((idx_r + 1'b1) == count_r);

  assign count_ok  = (count_r <= ple_pkg::cnt_t'(ple_pkg::CAPACITY));
  assign in_move   = (state_r == S_SHIFT_UP) || (state_r == S_SHIFT_DN) ||
                     (state_r == S_FLUSH);
  assign out_st_ok = (out_r.status == ple_pkg::ST_OK);

  // Works out the status of a command and which edit it asks for. Checks run
  // in the same order as the list semantics require, so a failure reports
  // the first rule that is broken.
  always_comb begin
    dec_ins  = 1'b0;
    dec_rem  = 1'b0;
    dec_rev  = 1'b0;
    dec_read = 1'b0;
    dec_st   = ple_pkg::ST_OK;
    dec_slot = '0;
    unique case (in_data.kind)
      ple_pkg::K_INS_FRONT: begin
        if (is_full) begin
          dec_st = ple_pkg::ST_FULL;
        end else begin
          dec_ins = 1'b1;
        end
      end
      ple_pkg::K_INS_AT: begin
        // An empty list accepts the element at any position.
        if (is_empty) begin
          dec_ins = 1'b1;
        end else if (pos_w > cnt_w + 1'b1) begin
          dec_st = ple_pkg::ST_TOO_LARGE;
        end else if (pos_w == '0) begin
          dec_st = ple_pkg::ST_BELOW_ONE;
        end else if (is_full) begin
          dec_st = ple_pkg::ST_FULL;
        end else begin
          dec_ins  = 1'b1;
          dec_slot = pos_w - 1'b1;
        end
      end
      ple_pkg::K_INS_END: begin
        if (is_full) begin
          dec_st = ple_pkg::ST_FULL;
        end else begin
          dec_ins  = 1'b1;
          dec_slot = cnt_w;
        end
      end
      ple_pkg::K_DEL_FRONT: begin
        if (is_empty) begin
          dec_st = ple_pkg::ST_EMPTY;
        end else begin
          dec_rem = 1'b1;
        end
      end
      ple_pkg::K_DEL_AT: begin
        if (is_empty) begin
          dec_st = ple_pkg::ST_EMPTY;
        end else if (pos_w == '0) begin
          dec_st = ple_pkg::ST_BELOW_ONE;
        end else if (pos_w > cnt_w) begin
          dec_st = ple_pkg::ST_TOO_LARGE;
        end else begin
          dec_rem  = 1'b1;
          dec_slot = pos_w - 1'b1;
        end
      end
      ple_pkg::K_DEL_END: begin
        if (is_empty) begin
          dec_st = ple_pkg::ST_EMPTY;
        end else begin
          dec_rem  = 1'b1;
          dec_slot = cnt_w - 1'b1;
        end
      end
      ple_pkg::K_REVERSE: begin
        if (is_empty) begin
          dec_st = ple_pkg::ST_EMPTY;
        end else begin
          dec_rev = 1'b1;
        end
      end
      ple_pkg::K_READ_ALL: begin
        if (is_empty) begin
          dec_st = ple_pkg::ST_EMPTY;
        end else begin
          dec_read = 1'b1;
        end
      end
      default: begin
        dec_st = ple_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer. Moving a block of elements is a pipelined copy: each cycle
  // reads one source word and writes the word read the cycle before, so the
  // write port is the only shared resource and is busy every cycle.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    mv_pend_nxt   = 1'b0;
    mv_dst_nxt    = mv_dst_r;
    slot_nxt      = slot_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    tmp_nxt       = tmp_r;
    st_nxt        = st_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    ram_raddr_a = idx_r[ple_pkg::IDX_W-1:0];
    ram_raddr_b = hi_r[ple_pkg::IDX_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = mv_dst_r;
    ram_wdata   = ram_rdata_a;

    // Second half of a pipelined move: commit the word read last cycle.
    if (mv_pend_r) begin
      ram_we = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_data.kind;
          value_nxt = in_data.value;
          st_nxt    = dec_st;
          slot_nxt  = ple_pkg::idx_t'(dec_slot);
          if (dec_ins) begin
            if (dec_slot == cnt_w) begin
              state_nxt = S_INS_WR;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_SHIFT_UP;
            end
          end else if (dec_rem) begin
            // The count drops now; the shift loop ends on the new count.
            count_nxt = count_r - 1'b1;
            if (dec_slot == cnt_w - 1'b1) begin
              state_nxt = S_RESP;
            end else begin
              idx_nxt   = ple_pkg::cnt_t'(dec_slot);
              state_nxt = S_SHIFT_DN;
            end
          end else if (dec_rev) begin
            idx_nxt = '0;
            hi_nxt  = count_r - 1'b1;
            if (count_r == ple_pkg::cnt_t'(1)) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_REV_RD;
            end
          end else if (dec_read) begin
            idx_nxt   = '0;
            state_nxt = S_RD_ADDR;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SHIFT_UP: begin
        // Opens a gap at slot_r, working down from the tail.
        ram_raddr_a = ple_pkg::idx_t'(idx_r - 1'b1);
        mv_pend_nxt = 1'b1;
        mv_dst_nxt  = idx_r[ple_pkg::IDX_W-1:0];
        if (idx_r == ple_pkg::cnt_t'(slot_r) + 1'b1) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_SHIFT_DN: begin
        // Closes the gap at slot_r, working up towards the tail.
        ram_raddr_a = ple_pkg::idx_t'(idx_r + 1'b1);
        mv_pend_nxt = 1'b1;
        mv_dst_nxt  = idx_r[ple_pkg::IDX_W-1:0];
        if ((idx_r + 1'b1) == count_r) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (kind_r == ple_pkg::K_INS_FRONT || kind_r == ple_pkg::K_INS_AT ||
            kind_r == ple_pkg::K_INS_END) begin
          state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = value_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RESP;
      end
      S_REV_RD: begin
        state_nxt = S_REV_WA;
      end
      S_REV_WA: begin
        // Both ends were read together; the low word is kept for the
        // second write.
        ram_we    = 1'b1;
        ram_waddr = idx_r[ple_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata_b;
        tmp_nxt   = ram_rdata_a;
        state_nxt = S_REV_WB;
      end
      S_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r[ple_pkg::IDX_W-1:0];
        ram_wdata = tmp_r;
        idx_nxt   = idx_r + 1'b1;
        hi_nxt    = hi_r - 1'b1;
        if ((idx_r + ple_pkg::cnt_t'(2)) < hi_r) begin
          state_nxt = S_REV_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        // The read address stays put, so the RAM output holds while the
        // output register is still occupied.
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ple_pkg::ST_OK;
          out_nxt.element       = ram_rdata_a;
          out_nxt.last          = rd_last;
          out_nxt.element_count = ple_pkg::ecnt_t'(count_r);
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD_ADDR;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = st_r;
          out_nxt.element       = '0;
          out_nxt.last          = 1'b1;
          out_nxt.element_count = ple_pkg::ecnt_t'(count_r);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      hi_r        <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      hi_r        <= hi_nxt;
      mv_pend_r   <= mv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_dst_r <= mv_dst_nxt;
    slot_r   <= slot_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    tmp_r    <= tmp_nxt;
    st_r     <= st_nxt;
    out_r    <= out_nxt;
  end

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (ple_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // The list never grows beyond the store.
  `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_ok, "element count above capacity")
  // The store is only written while a command is being worked off.
  `PLE_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !ram_we, "store written while idle")
  // Outside command acceptance the count only moves under the sequencer.
  `PLE_ASSERT_NXT(a_idle_count_hold, in_ready && !in_valid, $stable(count_r), "idle count moved")
  // A pending move write belongs to a shift or its flush.
  `PLE_ASSERT_IMP(a_move_in_shift, mv_pend_r, in_move, "move write outside a shift")
  // Only a read gives results that are not final, and those carry ok.
  `PLE_ASSERT_IMP(a_read_status, out_valid_r && !out_r.last, out_st_ok, "non-final result not ok")

endmodule : positional_list_engine

`default_nettype wire

FILE: rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, reads registered, old data on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule : ple_ram

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list commands through the engine and checks every result item
// against a predictor of the list kept alongside it. A short table of
// directed commands covers the empty list, both ends of every field and
// each refusal but ST_FULL. Random commands follow, swinging the list
// between empty and full. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import ple_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  positional_list_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One row of the directed table. Where the result can be read straight
  // off the command (refusals, the empty list, simple inserts) it is typed
  // in; otherwise the predictor supplies it.
  typedef struct {
    in_item_t cmd;
    bit       typed;
    st_t      status;
    ecnt_t    count;
  } list_row_t;

  // Predicted contents of the list: entry k holds position k+1.
  word_t       list_words [CAPACITY];
  int          list_len;

  out_item_t   pending_results [$];
  list_row_t   directed_rows [$];

  int unsigned mismatches;
  int unsigned results_taken;
  int          send_calm;
  int          recv_calm;
  int          send_gap;
  bit          held_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous ceiling: even a run of full-list reads, each result held
  // back by the longest receiver stall, finishes well inside this.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Idle cycles before the next item on one side. Now and then a calm
  // stretch with no idling at all is started, so that back-to-back items
  // meet every phase of the engine's work as well.
  function automatic int idle_cycles(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm_left = $urandom_range(6, 20);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Opens a gap at zero-based slot idx and writes the new element there.
  function automatic void open_slot(int idx, word_t v);
    int i;
    for (i = list_len; i > idx; i--) begin
      list_words[i] = list_words[i-1];
    end
    list_words[idx] = v;
    list_len++;
  endfunction

  // Closes the gap left by removing zero-based slot idx.
  function automatic void close_slot(int idx);
    int i;
    for (i = idx; i + 1 < list_len; i++) begin
      list_words[i] = list_words[i+1];
    end
    list_len--;
  endfunction

  // Applies one command to the predicted list and queues the result items
  // it should produce: one per element for a read of a non-empty list, a
  // single status item for everything else.
  function automatic void apply_command(in_item_t cmd);
    st_t       st;
    out_item_t res;
    word_t     tmp;
    int        a;
    int        b;
    st = ST_OK;
    case (cmd.kind)
      K_INS_FRONT: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else open_slot(0, cmd.value);
      end
      K_INS_AT: begin
        // An empty list takes the element whatever the position says.
        if (list_len == 0) open_slot(0, cmd.value);
        else if (cmd.position > list_len + 1) st = ST_TOO_LARGE;
        else if (cmd.position == 0) st = ST_BELOW_ONE;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else open_slot(int'(cmd.position) - 1, cmd.value);
      end
      K_INS_END: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else open_slot(list_len, cmd.value);
      end
      K_DEL_FRONT: begin
        if (list_len == 0) st = ST_EMPTY;
        else close_slot(0);
      end
      K_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (cmd.position == 0) st = ST_BELOW_ONE;
        else if (cmd.position > list_len) st = ST_TOO_LARGE;
        else close_slot(int'(cmd.position) - 1);
      end
      K_DEL_END: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_len--;
      end
      K_REVERSE: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          a = 0;
          b = list_len - 1;
          while (a < b) begin
            tmp           = list_words[a];
            list_words[a] = list_words[b];
            list_words[b] = tmp;
            a++;
            b--;
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (a = 0; a < list_len; a++) begin
            res.status        = ST_OK;
            res.element       = list_words[a];
            res.last          = (a + 1 == list_len);
            res.element_count = ecnt_t'(list_len);
            pending_results.push_back(res);
          end
          return;
        end
      end
    endcase
    res.status        = st;
    res.element       = '0;
    res.last          = 1'b1;
    res.element_count = ecnt_t'(list_len);
    pending_results.push_back(res);
  endfunction

  function automatic void add_row(kind_t kind, int pos, word_t v, bit typed,
                                  st_t st, int cnt);
    list_row_t row;
    row.cmd.kind     = kind;
    row.cmd.position = pos[POS_W-1:0];
    row.cmd.value    = v;
    row.typed        = typed;
    row.status       = st;
    row.count        = ecnt_t'(cnt);
    directed_rows.push_back(row);
  endfunction

  // Offers one command and waits for it to be taken. The gap before the
  // following item is drawn here, so that valid drops straight after the
  // handshake whenever that item is not to follow at once.
  task automatic send_command(in_item_t cmd, bit typed, st_t st, ecnt_t cnt);
    if (send_gap > 0) begin
      repeat (send_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    apply_command(cmd);
    if (typed) begin
      pending_results[pending_results.size()-1].status        = st;
      pending_results[pending_results.size()-1].element       = '0;
      pending_results[pending_results.size()-1].last          = 1'b1;
      pending_results[pending_results.size()-1].element_count = cnt;
    end
    send_gap = idle_cycles(send_calm);
    if (send_gap > 0) in_valid <= 1'b0;
  endtask

  // Holds the input quiet until every expected result item has arrived.
  // When a gap was drawn after the last handshake, valid is already low.
  task automatic drain_results();
    if (send_gap == 0) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item: status %0d element %0d last %0d count %0d",
                 got.status, got.element, got.last, got.element_count);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.element !== want.element ||
        got.last !== want.last || got.element_count !== want.element_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: st %0d/%0d elem %0d/%0d last %0d/%0d cnt %0d/%0d (exp/act)",
                 want.status, got.status, want.element, got.element,
                 want.last, got.last, want.element_count, got.element_count);
    end
  endtask

  // Picks a command kind. While the list is growing most commands insert;
  // while it shrinks most delete. Reverse and read are mixed in throughout.
  function automatic kind_t pick_kind(bit growing);
    int r;
    int sub;
    r   = $urandom_range(0, 99);
    sub = $urandom_range(0, 2);
    if (r < (growing ? 75 : 15)) begin
      case (sub)
        0:       return K_INS_FRONT;
        1:       return K_INS_AT;
        default: return K_INS_END;
      endcase
    end
    if (r < (growing ? 80 : 75)) begin
      case (sub)
        0:       return K_DEL_FRONT;
        1:       return K_DEL_AT;
        default: return K_DEL_END;
      endcase
    end
    if (r < 88) return K_REVERSE;
    return K_READ_ALL;
  endfunction

  // Receiver: takes result items with random stalls. Once, early in the
  // random part, it holds off for a long stretch while the sender keeps
  // offering commands, so that the engine backs up and stalls its input.
  initial begin
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && results_taken == 45) begin
        held_off = 1'b1;
        gap      = 300;
      end else begin
        gap = idle_cycles(recv_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      check_result(out_data);
    end
  end

  // Sender and overall sequencing.
  initial begin
    in_item_t cmd;
    bit       growing;
    int       full_hits;
    int       empty_hits;
    int       n;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    list_len      = 0;
    mismatches    = 0;
    results_taken = 0;
    send_calm     = 0;
    recv_calm     = 0;
    send_gap      = 0;
    held_off      = 1'b0;
    growing       = 1'b1;
    full_hits     = 0;
    empty_hits    = 0;

    // Every command on the empty list is refused with the empty status,
    // apart from the inserts; insert-at takes even position zero there.
    add_row(K_READ_ALL,  0,   32'h0,         1, ST_EMPTY,     0);
    add_row(K_DEL_FRONT, 0,   32'h0,         1, ST_EMPTY,     0);
    add_row(K_DEL_AT,    5,   32'h0,         1, ST_EMPTY,     0);
    add_row(K_DEL_END,   0,   32'h0,         1, ST_EMPTY,     0);
    add_row(K_REVERSE,   0,   32'h0,         1, ST_EMPTY,     0);
    add_row(K_INS_AT,    0,   32'h8000_0000, 1, ST_OK,        1);
    add_row(K_INS_FRONT, 0,   32'h7FFF_FFFF, 1, ST_OK,        2);
    add_row(K_INS_END,   0,   32'hFFFF_FFFF, 1, ST_OK,        3);
    // Positional inserts: too far out, below one, then the one-past-the-end
    // position, which appends, and a plain one in the middle.
    add_row(K_INS_AT,    255, 32'h1234_5678, 1, ST_TOO_LARGE, 3);
    add_row(K_INS_AT,    0,   32'h1234_5678, 1, ST_BELOW_ONE, 3);
    add_row(K_INS_AT,    4,   32'h0,         1, ST_OK,        4);
    add_row(K_INS_AT,    2,   32'h5555_5555, 1, ST_OK,        5);
    add_row(K_READ_ALL,  0,   32'h0,         0, ST_OK,        0);
    add_row(K_REVERSE,   0,   32'h0,         1, ST_OK,        5);
    add_row(K_READ_ALL,  0,   32'h0,         0, ST_OK,        0);
    // Positional deletes: below one and beyond the end are checked in that
    // order, then deletes at the head, at the tail and from both ends.
    add_row(K_DEL_AT,    0,   32'h0,         1, ST_BELOW_ONE, 5);
    add_row(K_DEL_AT,    6,   32'h0,         1, ST_TOO_LARGE, 5);
    add_row(K_DEL_AT,    1,   32'h0,         1, ST_OK,        4);
    add_row(K_DEL_AT,    4,   32'h0,         1, ST_OK,        3);
    add_row(K_DEL_FRONT, 0,   32'h0,         1, ST_OK,        2);
    add_row(K_DEL_END,   0,   32'h0,         1, ST_OK,        1);
    add_row(K_REVERSE,   0,   32'h0,         1, ST_OK,        1);
    add_row(K_READ_ALL,  0,   32'h0,         0, ST_OK,        0);
    // Emptying a one-element list from the end must leave it fully empty.
    add_row(K_DEL_END,   0,   32'h0,         1, ST_OK,        0);
    add_row(K_READ_ALL,  0,   32'h0,         1, ST_EMPTY,     0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].count);
    end

    // The sender pauses here until the engine has worked everything off.
    drain_results();

    // Random part. The list is driven up towards full until six commands have
    // met it full, then run down until three have met it empty, and round again.
    for (n = 0; n < 105; n++) begin
      if (n == 52) drain_results();
      if (growing && list_len == CAPACITY) full_hits++;
      if (!growing && list_len == 0) empty_hits++;
      if (growing && full_hits >= 6) begin
        growing   = 1'b0;
        full_hits = 0;
      end else if (!growing && empty_hits >= 3) begin
        growing    = 1'b1;
        empty_hits = 0;
      end
      cmd.kind  = pick_kind(growing);
      cmd.value = $urandom;
      // Mostly positions near the list's length, so that both valid and
      // just-out-of-range positions come up; sometimes any byte at all.
      if ($urandom_range(0, 4) == 0) cmd.position = POS_W'($urandom_range(0, 255));
      else cmd.position = POS_W'($urandom_range(0, list_len + 2));
      send_command(cmd, 1'b0, ST_OK, '0);
    end

    drain_results();
    // Let the longest command finish in case something stray is produced.
    repeat (3 * CAPACITY + 20) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
